// ===== design/gpsa_pkg.sv =====
// Package for the palette slot assigner: palette table and fixed codes.
package gpsa_pkg;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW = 4;
  localparam int unsigned ChanW = 8;
  localparam int unsigned DistW = 18;

  localparam logic [SlotW-1:0] WhiteSlot = 4'd7;
  localparam logic [NumSlots-1:0] NeutralMaskReset = 16'h8989;

  localparam logic [ChanW-1:0] LvlZero = 8'h00;
  localparam logic [ChanW-1:0] LvlLow  = 8'h55;
  localparam logic [ChanW-1:0] LvlHigh = 8'hAA;
  localparam logic [ChanW-1:0] LvlFull = 8'hFF;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // ANSI palette entry, table order.
  function automatic rgb_t pal_rgb(input logic [SlotW-1:0] idx);
    rgb_t c;
    case (idx)
      4'd0:  c = '{LvlZero, LvlZero, LvlZero};
      4'd1:  c = '{LvlHigh, LvlZero, LvlZero};
      4'd2:  c = '{LvlZero, LvlHigh, LvlZero};
      4'd3:  c = '{LvlHigh, LvlLow,  LvlZero};
      4'd4:  c = '{LvlZero, LvlZero, LvlHigh};
      4'd5:  c = '{LvlHigh, LvlZero, LvlHigh};
      4'd6:  c = '{LvlZero, LvlHigh, LvlHigh};
      4'd7:  c = '{LvlHigh, LvlHigh, LvlHigh};
      4'd8:  c = '{LvlLow,  LvlLow,  LvlLow};
      4'd9:  c = '{LvlFull, LvlLow,  LvlLow};
      4'd10: c = '{LvlLow,  LvlFull, LvlLow};
      4'd11: c = '{LvlFull, LvlFull, LvlLow};
      4'd12: c = '{LvlLow,  LvlLow,  LvlFull};
      4'd13: c = '{LvlFull, LvlLow,  LvlFull};
      4'd14: c = '{LvlLow,  LvlFull, LvlFull};
      default: c = '{LvlFull, LvlFull, LvlFull};
    endcase
    return c;
  endfunction

  // Absolute difference of two channel values.
  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== design/greedy_palette_slot_assign_top.sv =====
// Greedy nearest-color palette slot assigner: top level with scan sequencer.
// After an input transfer the single distance unit scores the palette entries in
//   table order, one per cycle, holding on the last while a result is unclaimed.
//   m_axis_tvalid rises when the scan finishes; no request is taken during the scan.
// A finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous): taken marks cleared, neutral mask 0x8989,
//   sequencer idle, no result pending.
module greedy_palette_slot_assign_top
  import gpsa_pkg::*;
#(
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: neutral_mask
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] red, [15:8] green, [23:16] blue
  input  logic [1:0]  s_axis_tuser,  // [0] neutral_only, [1] new_set
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [3:0] slot, [7:4] zero
  output logic [0:0]  m_axis_tuser   // [0] no_free_slot
);

  localparam logic [SlotW-1:0] LastIdx = SlotW'(PALETTE_SIZE - 1);

  // Sequencer states
  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic                state_q, state_d;
  logic [SlotW-1:0]    idx_q, idx_d;
  logic [NumSlots-1:0] taken_q, taken_d;
  logic [NumSlots-1:0] neutral_mask_q;
  logic [NumSlots-1:0] elig_q, elig_d;
  rgb_t                req_q;
  logic                found_q, found_d;
  logic [SlotW-1:0]    best_q, best_d;
  logic [DistW-1:0]    best_dist_q, best_dist_d;
  logic                out_valid_q, out_valid_d;
  logic [SlotW-1:0]    out_slot_q;
  logic                out_nofree_q;

  logic                in_xfer;
  logic                out_xfer;
  logic                out_free;
  logic                last;
  logic                step;
  logic                finish;
  rgb_t                pal;
  logic [DistW-1:0]    cand_dist;
  logic                cand_take;
  logic                found_nxt;
  logic [SlotW-1:0]    best_nxt;
  logic [NumSlots-1:0] taken_base;

  assign in_xfer  = s_axis_tvalid & s_axis_tready;
  assign out_xfer = m_axis_tvalid & m_axis_tready;
  assign out_free = ~out_valid_q | m_axis_tready;
  assign last     = (idx_q == LastIdx);
  // Hold on the last entry while the previous result is still unclaimed.
  assign step     = (state_q == StScan) & (~last | out_free);
  assign finish   = step & last;

  // Shared distance unit: one palette entry per cycle, held on the last entry while a result is unclaimed.
  always_comb begin
    logic [ChanW-1:0] dr, dg, db;
    pal = pal_rgb(idx_q);
    dr  = abs_diff(req_q.red,   pal.red);
    dg  = abs_diff(req_q.green, pal.green);
    db  = abs_diff(req_q.blue,  pal.blue);
    cand_dist = DistW'(dr * dr) + DistW'(dg * dg) + DistW'(db * db);
  end

  // Strict compare keeps the first minimum in table order.
  assign cand_take = elig_q[idx_q] & (~found_q | (cand_dist < best_dist_q));
  assign found_nxt = found_q | elig_q[idx_q];
  assign best_nxt  = cand_take ? idx_q : best_q;

  // Clear the marks first when the request opens a new set.
  assign taken_base = s_axis_tuser[1] ? '0 : taken_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    taken_d     = taken_q;
    elig_d      = elig_q;
    found_d     = found_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    out_valid_d = out_valid_q;

    if (out_xfer) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          taken_d = taken_base;
          elig_d  = ~taken_base & (s_axis_tuser[0] ? neutral_mask_q : '1);
          idx_d   = '0;
          found_d = 1'b0;
          best_d  = WhiteSlot;
          state_d = StScan;
        end
      end
      StScan: begin
        if (step) begin
          found_d = found_nxt;
          best_d  = best_nxt;
          if (cand_take) begin
            best_dist_d = cand_dist;
          end
          idx_d = idx_q + 1'b1;
        end
        if (finish) begin
          // White is marked even when it was not eligible.
          taken_d     = taken_q | (NumSlots'(1) << best_nxt);
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      taken_q        <= '0;
      neutral_mask_q <= NeutralMaskReset;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        neutral_mask_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers: no reset needed.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    elig_q      <= elig_d;
    found_q     <= found_d;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    if (in_xfer) begin
      req_q.red   <= s_axis_tdata[7:0];
      req_q.green <= s_axis_tdata[15:8];
      req_q.blue  <= s_axis_tdata[23:16];
    end
    if (finish) begin
      out_slot_q   <= best_nxt;
      out_nofree_q <= ~found_nxt;
    end
  end

  assign s_axis_tready   = (state_q == StIdle);
  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = {4'b0000, out_slot_q};
  assign m_axis_tuser[0] = out_nofree_q;

endmodule

// ===== design/gpsa_checker.sv =====
// Port-level checker for the palette slot assigner, bound to the top level.
module gpsa_assertions
  import gpsa_pkg::*;
#(
  parameter int unsigned PALETTE_SIZE = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // Stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // No free slot always reports White.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[3:0] == WhiteSlot)
    else $error("no_free_slot without White slot");

  // A found slot lies inside the scanned palette.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> 32'(m_axis_tdata[3:0]) < PALETTE_SIZE
      && m_axis_tdata[7:4] == 4'b0000)
    else $error("slot outside palette");

  // The scan keeps the request side busy after a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken during scan");

endmodule

bind greedy_palette_slot_assign_top gpsa_assertions #(
  .PALETTE_SIZE(PALETTE_SIZE)
) u_gpsa_assertions (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/gpsa_checker.sv =====
// Checker for the palette slot assigner: predicts each slot and compares results.
module gpsa_checker
  import gpsa_pkg::*;
#(
  parameter int unsigned PALETTE_SIZE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [0:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          no_free_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Palette as RRGGBB, slot 15 in the top bits.
  localparam logic [NumSlots*24-1:0] AnsiRgb = {
    24'hFFFFFF, 24'h55FFFF, 24'hFF55FF, 24'h5555FF,
    24'hFFFF55, 24'h55FF55, 24'hFF5555, 24'h555555,
    24'hAAAAAA, 24'h00AAAA, 24'hAA00AA, 24'h0000AA,
    24'hAA5500, 24'h00AA00, 24'hAA0000, 24'h000000
  };

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             no_free;
  } slot_result_t;

  slot_result_t     expected_slots[$];
  logic [15:0]      neutral_mask;
  logic [15:0]      taken_marks;

  task automatic report_fault(input string msg);
    fail_count_o++;
    if (fail_count_o <= 10) $display("%t checker: %s", $realtime, msg);
  endtask

  // Nearest free eligible slot; first in table order wins a tie.
  function automatic slot_result_t nearest_free_slot(input logic [7:0] red,
                                                     input logic [7:0] green,
                                                     input logic [7:0] blue,
                                                     input logic [15:0] eligible);
    slot_result_t res;
    logic [23:0]  entry;
    int           dr, dg, db, sq_dist, best_dist;
    logic         found;
    res       = '{slot: WhiteSlot, no_free: 1'b1};
    best_dist = 0;
    found     = 1'b0;
    for (int i = 0; i < int'(PALETTE_SIZE) && i < int'(NumSlots); i++) begin
      if (eligible[i]) begin
        entry   = AnsiRgb[i*24 +: 24];
        dr      = int'(red)   - int'(entry[23:16]);
        dg      = int'(green) - int'(entry[15:8]);
        db      = int'(blue)  - int'(entry[7:0]);
        sq_dist = dr*dr + dg*dg + db*db;
        if (!found || sq_dist < best_dist) begin
          found     = 1'b1;
          best_dist = sq_dist;
          res.slot  = SlotW'(i);
        end
      end
    end
    res.no_free = !found;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    slot_result_t want;
    logic [15:0]  eligible;
    if (!rst_ni) begin
      neutral_mask = NeutralMaskReset;
      taken_marks  = '0;
      expected_slots.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      no_free_o    = 0;
    end else begin
      if (cfg_we_i) neutral_mask = cfg_wdata_i;

      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[1]) taken_marks = '0;
        eligible = ~taken_marks;
        if (s_axis_tuser[0]) eligible &= neutral_mask;
        want = nearest_free_slot(s_axis_tdata[7:0], s_axis_tdata[15:8],
                                 s_axis_tdata[23:16], eligible);
        // White is marked taken even when it was not eligible
        taken_marks[want.slot] = 1'b1;
        expected_slots.push_back(want);
      end

      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (m_axis_tuser[0]) no_free_o++;
        if (expected_slots.size() == 0) begin
          report_fault($sformatf("result with nothing expected: slot %0d flag %0b",
                                 m_axis_tdata[3:0], m_axis_tuser[0]));
        end else begin
          want = expected_slots.pop_front();
          if (m_axis_tdata[3:0] != want.slot || m_axis_tuser[0] != want.no_free ||
              m_axis_tdata[7:4] != 4'd0) begin
            report_fault($sformatf("expected slot %0d flag %0b, got slot %0d flag %0b pad %h",
                                   want.slot, want.no_free, m_axis_tdata[3:0],
                                   m_axis_tuser[0], m_axis_tdata[7:4]));
          end
        end
      end
      pending_o = expected_slots.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Testbench top for the palette slot assigner: stimulus, stall patterns and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gpsa_pkg::*;

  localparam int unsigned PaletteSize = 16;
  localparam int          PhaseItems  = 50;
  localparam int          CycleLimit  = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue
  logic [1:0]  s_axis_tuser;   // [0] neutral_only, [1] new_set
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [3:0] slot, [7:4] zero
  logic [0:0]  m_axis_tuser;   // [0] no_free_slot

  int fail_count;
  int pending;
  int results;
  int no_free;
  int requests_sent;
  int mask_settings;
  int cycles;

  greedy_palette_slot_assign_top #(
    .PALETTE_SIZE(PaletteSize)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  gpsa_checker #(
    .PALETTE_SIZE(PaletteSize)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results),
    .no_free_o    (no_free)
  );

  // 100 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: fail and end the run if it is still going when the cycle limit is reached.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles == CycleLimit) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side backpressure: switch at random among stall modes, so stalls land
  // on every phase of the scan.
  initial begin : result_stall
    int mode;
    int mode_left;
    int step;
    m_axis_tready = 1'b0;
    mode      = 0;
    mode_left = 0;
    step      = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      step++;
      case (mode)
        0:       m_axis_tready <= 1'b1;                          // never stall
        1:       m_axis_tready <= $urandom_range(0, 1);          // coin toss
        2:       m_axis_tready <= ($urandom_range(0, 7) == 0);   // mostly stalled
        default: m_axis_tready <= ((step % 5) < 2);              // fixed rhythm
      endcase
    end
  end

  // Drive one request and hold it until the transfer. Enter and leave at a falling edge.
  task automatic send_request(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic neutral_only,
                              input logic new_set);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red};
    s_axis_tuser  <= {new_set, neutral_only};
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid for an idle gap of the given length.
  task automatic idle_sender(input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold off until every expected result has been seen, then load a new mask.
  task automatic drain_and_set_mask(input logic [15:0] mask);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mask;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    mask_settings++;
  endtask

  // Channel value: full random, a palette level, near a level, or next to a midpoint
  // between levels, where distances nearly tie.
  function automatic logic [7:0] pick_channel();
    logic [7:0] lvl;
    case ($urandom_range(0, 3))
      0: lvl = LvlZero;
      1: lvl = LvlLow;
      2: lvl = LvlHigh;
      default: lvl = LvlFull;
    endcase
    case ($urandom_range(0, 3))
      0:       return 8'($urandom);
      1:       return lvl;
      2:       return lvl + 8'($urandom_range(0, 6)) - 8'd3;
      default: return (lvl == LvlFull) ? 8'h80 : ((lvl == LvlHigh) ? 8'hD4 : 8'h2A);
    endcase
  endfunction

  // Random requests in bursts with random gaps; some stretches run back to back.
  task automatic run_random_phase(input int count);
    int burst;
    int gap;
    burst = $urandom_range(1, 20);
    for (int k = 0; k < count; k++) begin
      send_request(pick_channel(), pick_channel(), pick_channel(),
                   $urandom_range(0, 2) == 0, $urandom_range(0, 11) == 0);
      burst--;
      if (burst == 0) begin
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        idle_sender(gap);
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  initial begin : stimulus
    logic [15:0] phase_masks[8];
    rgb_t        color;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    requests_sent = 0;
    mask_settings = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: fill every slot, run out, tie, then exhaust the neutral slots.
    drain_and_set_mask(NeutralMaskReset);
    send_request(LvlZero, LvlZero, LvlZero, 1'b0, 1'b1);
    send_request(LvlFull, LvlFull, LvlFull, 1'b0, 1'b0);
    for (int i = 1; i < 15; i++) begin
      color = pal_rgb(SlotW'(i));
      send_request(color.red, color.green, color.blue, 1'b0, 1'b0);
    end
    send_request(8'h80, 8'h80, 8'h80, 1'b0, 1'b0);        // all taken: white and flag
    send_request(LvlLow, LvlZero, LvlZero, 1'b0, 1'b1);   // black and red tie
    repeat (6) send_request(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0);

    // Random phases, each under its own neutral mask, extremes included.
    phase_masks = '{16'h0000, 16'hFFFF, 16'($urandom), 16'h0001,
                    16'h8000, 16'($urandom), 16'($urandom), 16'h7FFE};
    for (int p = 0; p < 8; p++) begin
      drain_and_set_mask(phase_masks[p]);
      if (phase_masks[p] == 16'h0000) begin
        send_request(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0);
      end
      run_random_phase(PhaseItems);
    end

    // Drain, then keep watching so any stray result from the scan shows.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (PaletteSize + 8) @(negedge clk_i);

    $display("Summary: %0d requests under %0d neutral masks, %0d results checked",
             requests_sent, mask_settings, results);
    $display("  %0d of them had no free slot; traffic mixed bursts, gaps and stalls",
             no_free);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/gpsa_pkg.sv
design/greedy_palette_slot_assign_top.sv
design/gpsa_checker.sv
tb/gpsa_checker.sv
tb/testbench.sv
